### hdl/lcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_pkg: shared definitions of the character LCD writer
// Request codes, LCD command bytes, slot cache control types and the
// character tables (Latin lookalikes and the built-in glyph rows).
// ----------------------------------------------------------------------------
package lcw_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int USED_W      = 4;
    localparam int CELL_W      = 4;
    localparam int ROW_W       = 3;
    localparam int PIXEL_W     = 5;
    localparam int ENTRY_W     = 8;
    localparam int GLYPH_ADDR_W = ENTRY_W + ROW_W;

    localparam logic [CELL_W-1:0] LAST_CELL  = 4'd9;
    localparam logic [CELL_W-1:0] ROW1_CELL  = 4'd5;
    localparam logic [ROW_W-1:0]  LAST_ROW   = 3'd7;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_CGRAM   = 8'h40;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_ADDR   = 8'h40;
    localparam logic [7:0] BACKSLASH   = 8'h5C;
    localparam logic [7:0] DIRECT_LIMIT = 8'd128;
    localparam logic [7:0] BUILTIN_BASE = 8'hF0;
    localparam logic [7:0] BUILTIN_END  = 8'hFB;
    localparam logic [7:0] STORE_SPLIT  = 8'd223;
    localparam logic [7:0] STORE_OFS_HI = 8'd69;
    localparam logic [7:0] STORE_OFS_LO = 8'd21;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_CURSOR = 2'd2,
        FUNC_LOAD   = 2'd3
    } func_t;

    typedef struct packed {
        logic       clear;
        logic       write;
        logic [7:0] code;
    } slot_ctrl_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic [USED_W-1:0]     used;
        logic                  full;
    } slot_stat_t;

    localparam logic [PIXEL_W-1:0] BUILTIN_GLYPHS [0:10][0:7] = '{
        '{5'd0,  5'd4,  5'd2,  5'd31, 5'd2,  5'd4,  5'd0,  5'd0},
        '{5'd0,  5'd4,  5'd8,  5'd31, 5'd8,  5'd4,  5'd0,  5'd0},
        '{5'd4,  5'd14, 5'd21, 5'd4,  5'd4,  5'd0,  5'd0,  5'd0},
        '{5'd0,  5'd0,  5'd0,  5'd4,  5'd4,  5'd21, 5'd14, 5'd4},
        '{5'd8,  5'd20, 5'd20, 5'd8,  5'd5,  5'd6,  5'd5,  5'd5},
        '{5'd14, 5'd17, 5'd17, 5'd31, 5'd27, 5'd27, 5'd31, 5'd0},
        '{5'd14, 5'd16, 5'd16, 5'd31, 5'd27, 5'd27, 5'd31, 5'd0},
        '{5'd17, 5'd18, 5'd23, 5'd9,  5'd19, 5'd4,  5'd7,  5'd0},
        '{5'd31, 5'd17, 5'd31, 5'd4,  5'd4,  5'd6,  5'd7,  5'd4},
        '{5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd24, 5'd0},
        '{5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd0}
    };

    // Set-DDRAM command for a cell; cells of the second line start at 0x40.
    function automatic logic [7:0] ddram_cmd(input logic [CELL_W-1:0] cell_no);
        logic [7:0] addr;
        begin
            if (cell_no >= ROW1_CELL)
            begin
                addr = ROW1_ADDR + {4'b0, cell_no} - {4'b0, ROW1_CELL};
            end
            else
            begin
                addr = {4'b0, cell_no};
            end
            ddram_cmd = CMD_DDRAM | addr;
        end
    endfunction

    // Latin character that looks like a Cyrillic code, or zero if none does.
    function automatic logic [7:0] lookalike(input logic [7:0] code);
        begin
            unique case (code)
                8'h80:   lookalike = "A";
                8'h82:   lookalike = "B";
                8'h85:   lookalike = "E";
                8'h8A:   lookalike = "K";
                8'h8C:   lookalike = "M";
                8'h8D:   lookalike = "H";
                8'h8E:   lookalike = "O";
                8'h90:   lookalike = "P";
                8'h91:   lookalike = "C";
                8'h92:   lookalike = "T";
                8'h95:   lookalike = "X";
                8'hA0:   lookalike = "a";
                8'hA5:   lookalike = "e";
                8'hAE:   lookalike = "o";
                8'hE0:   lookalike = "p";
                8'hE1:   lookalike = "c";
                8'hE5:   lookalike = "x";
                default: lookalike = 8'h00;
            endcase
        end
    endfunction

    // Glyph store entry that holds the pixel rows of a code.
    function automatic logic [ENTRY_W-1:0] store_entry(input logic [7:0] code);
        begin
            if (code > STORE_SPLIT)
            begin
                store_entry = code - STORE_OFS_HI;
            end
            else
            begin
                store_entry = code - STORE_OFS_LO;
            end
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] builtin_row(input logic [7:0] code,
                                                       input logic [ROW_W-1:0] row);
        logic [7:0] idx;
        begin
            idx = code - BUILTIN_BASE;
            if (idx < 8'd11)
            begin
                builtin_row = BUILTIN_GLYPHS[idx[3:0]][row];
            end
            else
            begin
                builtin_row = '0;
            end
        end
    endfunction

endpackage

`default_nettype wire

### hdl/lcw_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_req_if / lcw_rsp_if: request and byte channels of the LCD writer
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface lcw_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] char_code;
    logic [3:0] cell_req;
    logic [7:0] glyph_number;
    logic [2:0] row_number;
    logic [4:0] row_bits;

    modport source (output valid, func, char_code, cell_req, glyph_number,
                    row_number, row_bits, input ready);
    modport sink   (input valid, func, char_code, cell_req, glyph_number,
                    row_number, row_bits, output ready);
endinterface

interface lcw_rsp_if;
    logic       valid;
    logic       ready;
    logic       register_select;
    logic [7:0] lcd_byte;
    logic       last;

    modport source (output valid, register_select, lcd_byte, last, input ready);
    modport sink   (input valid, register_select, lcd_byte, last, output ready);
endinterface

`default_nettype wire

### hdl/lcw_glyph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_glyph_ram: simple dual-port RAM with a registered read
// One write port and one read port; read data appears in the cycle after the address.
// ----------------------------------------------------------------------------
module lcw_glyph_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 5
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] store_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/lcw_slot_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_slot_cache: codes held in the custom glyph slots
// Records which code sits in each filled slot and looks a code up.
// ----------------------------------------------------------------------------
module lcw_slot_cache (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lcw_pkg::slot_ctrl_t ctrl,
    input  wire logic [7:0]          lookup_code,
    output lcw_pkg::slot_stat_t      stat
);

    logic [7:0]                  slot_code_reg  [0:lcw_pkg::SLOT_COUNT-1];
    logic [7:0]                  slot_code_next [0:lcw_pkg::SLOT_COUNT-1];
    logic [lcw_pkg::USED_W-1:0]  used_reg;
    logic [lcw_pkg::USED_W-1:0]  used_next;
    logic                        full;

    assign full = (used_reg >= lcw_pkg::USED_W'(lcw_pkg::SLOT_COUNT));

    // Only filled slots take part; the lowest matching slot wins.
    always_comb
    begin
        stat.hit     = 1'b0;
        stat.hit_idx = '0;
        for (int i = lcw_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if ((lcw_pkg::USED_W'(i) < used_reg) && (slot_code_reg[i] == lookup_code))
            begin
                stat.hit     = 1'b1;
                stat.hit_idx = lcw_pkg::SLOT_IDX_W'(i);
            end
        end
        stat.used = used_reg;
        stat.full = full;
    end

    always_comb
    begin
        used_next = used_reg;
        for (int i = 0; i < lcw_pkg::SLOT_COUNT; i++)
        begin
            slot_code_next[i] = slot_code_reg[i];
        end
        if (ctrl.clear)
        begin
            used_next = '0;
        end
        else if (ctrl.write && !full)
        begin
            for (int i = 0; i < lcw_pkg::SLOT_COUNT; i++)
            begin
                if (used_reg == lcw_pkg::USED_W'(i))
                begin
                    slot_code_next[i] = ctrl.code;
                end
            end
            used_next = used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < lcw_pkg::SLOT_COUNT; i++)
            begin
                slot_code_reg[i] <= '0;
            end
        end
        else
        begin
            used_reg <= used_next;
            for (int i = 0; i < lcw_pkg::SLOT_COUNT; i++)
            begin
                slot_code_reg[i] <= slot_code_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/lcd_char_writer_with_glyph_slots.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_char_writer_with_glyph_slots: character LCD byte sequencer
// Turns write, clear, cursor and glyph-load requests into LCD bus bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one request item; the rsp channel delivers the
//   command and data bytes it causes, one item per byte, with last set on
//   the final byte of each request. A glyph row load gives no byte at all.
//   Requests are taken one at a time: req.ready is high while the sequencer
//   is idle, even when the final byte of the previous request still waits
//   in the output register.
//   After acceptance the sequencer leaves idle and then loads the first
//   byte into the output register. Throughput: while rsp does not stall,
//   the sequencer emits one byte per cycle, and a character whose glyph
//   is loaded into a new slot sends its 8 pixel rows, one row per cycle,
//   from the glyph RAM through its single read port or, for built-in codes,
//   from the constant table. A glyph row load only writes the RAM.
//   When rsp stalls, the output register holds its byte and the sequencer
//   waits in place; nothing is dropped.
//   Reset puts the cursor at cell 0 and empties all glyph slots. The glyph
//   RAM is not cleared; entries must be loaded before a code that uses
//   them is written.
// ----------------------------------------------------------------------------
module lcd_char_writer_with_glyph_slots (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lcw_req_if.sink    req,
    lcw_rsp_if.source  rsp
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DDRAM  = 8'b0000_0010,
        S_CHAR   = 8'b0000_0100,
        S_ROW    = 8'b0000_1000,
        S_DDRAM2 = 8'b0001_0000,
        S_SLOT   = 8'b0010_0000,
        S_HOME   = 8'b0100_0000,
        S_CMD    = 8'b1000_0000
    } state_t;

    state_t                              state_reg, state_next;
    logic [7:0]                          code_reg, code_next;
    logic [7:0]                          cmd_reg, cmd_next;
    logic [lcw_pkg::CELL_W-1:0]          cursor_reg, cursor_next;
    logic [lcw_pkg::ROW_W-1:0]           row_reg, row_next;
    logic [lcw_pkg::ENTRY_W-1:0]         entry_reg, entry_next;

    logic                                out_valid_reg, out_valid_next;
    logic                                out_rs_reg, out_rs_next;
    logic [7:0]                          out_byte_reg, out_byte_next;
    logic                                out_last_reg, out_last_next;

    lcw_pkg::slot_ctrl_t                 slot_ctrl;
    lcw_pkg::slot_stat_t                 slot_stat;

    logic                                ram_we;
    logic [lcw_pkg::GLYPH_ADDR_W-1:0]    ram_waddr;
    logic [lcw_pkg::GLYPH_ADDR_W-1:0]    ram_raddr;
    logic [lcw_pkg::PIXEL_W-1:0]         ram_rdata;

    logic                                out_free;
    logic                                emit;
    logic                                emit_rs;
    logic [7:0]                          emit_byte;
    logic                                emit_last;

    logic                                wrap;
    logic [lcw_pkg::CELL_W-1:0]          cursor_adv;
    logic [lcw_pkg::CELL_W-1:0]          cell_sat;
    logic [7:0]                          sub_char;
    logic                                is_miss;
    logic [7:0]                          char_byte;
    logic [lcw_pkg::PIXEL_W-1:0]         row_pixels;

    // The slot cache compares against the code of the request at work.
    lcw_slot_cache u_slot_cache (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (slot_ctrl),
        .lookup_code (code_reg),
        .stat        (slot_stat)
    );

    // The read address follows the next row, so the registered read data
    // always belongs to the row the sequencer currently holds.
    assign ram_waddr = {req.glyph_number, req.row_number};
    assign ram_raddr = {entry_next, row_next};

    lcw_glyph_ram #(
        .ADDR_W (lcw_pkg::GLYPH_ADDR_W),
        .DATA_W (lcw_pkg::PIXEL_W)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.row_bits),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign wrap       = (cursor_reg == lcw_pkg::LAST_CELL);
    assign cursor_adv = wrap ? '0 : cursor_reg + 1'b1;
    assign cell_sat   = (req.cell_req > lcw_pkg::LAST_CELL) ? lcw_pkg::LAST_CELL
                                                            : req.cell_req;
    assign sub_char   = lcw_pkg::lookalike(code_reg);

    // Byte that follows the cursor command of a write: plain ASCII other than
    // backslash first, then lookalikes, reserved top codes and the slot cache.
    always_comb
    begin
        is_miss   = 1'b0;
        char_byte = lcw_pkg::BACKSLASH;
        priority if ((code_reg < lcw_pkg::DIRECT_LIMIT) && (code_reg != lcw_pkg::BACKSLASH))
        begin
            char_byte = code_reg;
        end
        else if (sub_char != 8'h00)
        begin
            char_byte = sub_char;
        end
        else if (code_reg >= lcw_pkg::BUILTIN_END)
        begin
            char_byte = lcw_pkg::BACKSLASH;
        end
        else if (slot_stat.hit)
        begin
            char_byte = {5'b0, slot_stat.hit_idx};
        end
        else if (slot_stat.full)
        begin
            char_byte = lcw_pkg::BACKSLASH;
        end
        else
        begin
            is_miss = 1'b1;
        end
    end

    // Built-in glyphs come from the constant table, all others from the RAM.
    assign row_pixels = (code_reg >= lcw_pkg::BUILTIN_BASE)
                      ? lcw_pkg::builtin_row(code_reg, row_reg)
                      : ram_rdata;

    always_comb
    begin
        state_next  = state_reg;
        code_next   = code_reg;
        cmd_next    = cmd_reg;
        cursor_next = cursor_reg;
        row_next    = row_reg;
        entry_next  = entry_reg;
        emit        = 1'b0;
        emit_rs     = 1'b0;
        emit_byte   = 8'h00;
        emit_last   = 1'b0;
        ram_we      = 1'b0;
        slot_ctrl   = '{clear: 1'b0, write: 1'b0, code: code_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (lcw_pkg::func_t'(req.func))
                        lcw_pkg::FUNC_WRITE:
                        begin
                            code_next  = req.char_code;
                            entry_next = lcw_pkg::store_entry(req.char_code);
                            row_next   = '0;
                            state_next = S_DDRAM;
                        end
                        lcw_pkg::FUNC_CLEAR:
                        begin
                            slot_ctrl.clear = 1'b1;
                            cursor_next     = '0;
                            cmd_next        = lcw_pkg::CMD_CLEAR;
                            state_next      = S_CMD;
                        end
                        lcw_pkg::FUNC_CURSOR:
                        begin
                            cursor_next = cell_sat;
                            cmd_next    = lcw_pkg::ddram_cmd(cell_sat);
                            state_next  = S_CMD;
                        end
                        lcw_pkg::FUNC_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DDRAM:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = lcw_pkg::ddram_cmd(cursor_reg);
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (is_miss)
                    begin
                        emit_byte  = lcw_pkg::CMD_CGRAM
                                   | {2'b0, slot_stat.used[lcw_pkg::SLOT_IDX_W-1:0], 3'b000};
                        state_next = S_ROW;
                    end
                    else
                    begin
                        emit_rs     = 1'b1;
                        emit_byte   = char_byte;
                        emit_last   = !wrap;
                        cursor_next = cursor_adv;
                        state_next  = wrap ? S_HOME : S_IDLE;
                    end
                end
            end
            S_ROW:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_rs   = 1'b1;
                    emit_byte = {3'b0, row_pixels};
                    if (row_reg == lcw_pkg::LAST_ROW)
                    begin
                        state_next = S_DDRAM2;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            S_DDRAM2:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = lcw_pkg::ddram_cmd(cursor_reg);
                    state_next = S_SLOT;
                end
            end
            S_SLOT:
            begin
                if (out_free)
                begin
                    emit            = 1'b1;
                    emit_rs         = 1'b1;
                    emit_byte       = {4'b0, slot_stat.used};
                    emit_last       = !wrap;
                    slot_ctrl.write = 1'b1;
                    cursor_next     = cursor_adv;
                    state_next      = wrap ? S_HOME : S_IDLE;
                end
            end
            S_HOME:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = lcw_pkg::CMD_HOME;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMD:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_byte  = cmd_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: a new byte loads only when the slot is free.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rs_next    = out_rs_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_rs_next    = emit_rs;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            row_reg       <= '0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            row_reg       <= row_next;
            entry_reg     <= entry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        cmd_reg      <= cmd_next;
        out_rs_reg   <= out_rs_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.register_select = out_rs_reg;
    assign rsp.lcd_byte        = out_byte_reg;
    assign rsp.last            = out_last_reg;

endmodule

`default_nettype wire

### hdl/lcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcw_checker: port-level checks of the LCD writer
// Watches the request and byte channels and flags sequencing errors.
// ----------------------------------------------------------------------------
module lcw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_func,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic       rsp_register_select,
    input wire logic [7:0] rsp_lcd_byte,
    input wire logic       rsp_last
);

    // A stalled byte keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lcd_byte)
                                    && $stable(rsp_register_select) && $stable(rsp_last))
    else $error("stalled output byte changed");

    // While a request still owes bytes, no new request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
    else $error("request taken while previous one is unfinished");

    // A glyph row load produces no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_func == lcw_pkg::FUNC_LOAD) && !rsp_valid
        |=> !rsp_valid)
    else $error("glyph row load produced an output byte");

    // Clear and home commands always end their request.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_register_select
        && ((rsp_lcd_byte == lcw_pkg::CMD_CLEAR) || (rsp_lcd_byte == lcw_pkg::CMD_HOME))
        |-> rsp_last)
    else $error("clear or home command not marked last");

endmodule

bind lcd_char_writer_with_glyph_slots lcw_checker u_lcw_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .req_func            (req.func),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_register_select (rsp.register_select),
    .rsp_lcd_byte        (rsp.lcd_byte),
    .rsp_last            (rsp.last)
);

`default_nettype wire
